[rtl/core/pp4_pkg.sv]
`default_nettype none

package pp4_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DUR_W  = 18;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SYM_W  = 2;
  localparam int unsigned NUM_SYMS = 4;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_BURST  = 3'd0;
  localparam reg_idx_t REG_GAP0   = 3'd1;
  localparam reg_idx_t REG_GAP1   = 3'd2;
  localparam reg_idx_t REG_GAP2   = 3'd3;
  localparam reg_idx_t REG_GAP3   = 3'd4;
  localparam reg_idx_t REG_APPEND = 3'd5;

  // Reset values of the timing registers.
  localparam logic [DUR_W-1:0] BURST_RST = 18'd9678;
  localparam logic [DUR_W-1:0] GAP0_RST  = 18'd14516;
  localparam logic [DUR_W-1:0] GAP1_RST  = 18'd58061;
  localparam logic [DUR_W-1:0] GAP2_RST  = 18'd29028;
  localparam logic [DUR_W-1:0] GAP3_RST  = 18'd43545;
  localparam logic             APPEND_RST = 1'b1;

  // Reflected CRC-16 constants.
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'h8408;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Timing registers seen by the pulse sequencer.
  typedef struct packed {
    logic [DUR_W-1:0]                burst;
    logic [NUM_SYMS-1:0][DUR_W-1:0]  gap;
  } cfg_t;

  // One queued command: a byte to send as eight pulses, or the closing burst.
  typedef struct packed {
    logic              is_close;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Front sequencer states.
  typedef enum logic [1:0] {
    FS_DATA,
    FS_CRC_LO,
    FS_CRC_HI,
    FS_CLOSE
  } front_state_t;

  // One byte through the reflected CRC, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pp4_front.sv]
`default_nettype none

module pp4_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pp4_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        in_frame_end,
  input  wire logic                        append_crc,
  input  wire logic                        q_full,
  output logic                             q_push,
  output pp4_pkg::cmd_t                    q_wdata
);

  pp4_pkg::front_state_t state_r, state_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [15:0]           crc_upd;

  assign crc_upd = pp4_pkg::crc_byte(crc_r, in_data_byte);

  // State and CRC registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pp4_pkg::FS_DATA;
      crc_r   <= pp4_pkg::CRC_INIT;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Payload bytes go in one per transaction; at the frame end the CRC bytes (when
  // append_crc is set) and the closing command follow while the input is held off.
  always_comb begin
    state_nxt        = state_r;
    crc_nxt          = crc_r;
    in_ready         = 1'b0;
    q_push           = 1'b0;
    q_wdata.is_close = 1'b0;
    q_wdata.data     = in_data_byte;
    unique case (state_r)
      pp4_pkg::FS_DATA: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          q_push  = 1'b1;
          crc_nxt = crc_upd;
          if (in_frame_end) begin
            state_nxt = append_crc ? pp4_pkg::FS_CRC_LO : pp4_pkg::FS_CLOSE;
          end
        end
      end
      pp4_pkg::FS_CRC_LO: begin
        q_wdata.data = crc_r[7:0];
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = pp4_pkg::FS_CRC_HI;
        end
      end
      pp4_pkg::FS_CRC_HI: begin
        q_wdata.data = crc_r[15:8];
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = pp4_pkg::FS_CLOSE;
        end
      end
      pp4_pkg::FS_CLOSE: begin
        q_wdata.is_close = 1'b1;
        q_wdata.data     = '0;
        if (!q_full) begin
          q_push    = 1'b1;
          crc_nxt   = pp4_pkg::CRC_INIT;
          state_nxt = pp4_pkg::FS_DATA;
        end
      end
      default: begin
        state_nxt = pp4_pkg::FS_DATA;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/pp4_queue.sv]
`default_nettype none

module pp4_queue #(
  parameter int unsigned DEPTH = pp4_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pp4_pkg::cmd_t  wdata,
  input  wire logic           pop,
  output pp4_pkg::cmd_t       head,
  output logic                full,
  output logic                empty
);

  // DEPTH must be a power of two, at least two.
  localparam int unsigned AW = $clog2(DEPTH);

  pp4_pkg::cmd_t   entries_r [DEPTH];
  logic [AW:0]     wr_ptr_r, rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                 (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign head  = entries_r[rd_ptr_r[AW-1:0]];

  // Pointers carry one wrap bit to tell full from empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r[AW-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pp4_back.sv]
`default_nettype none

module pp4_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pp4_pkg::cfg_t              cfg,
  input  wire logic                       q_empty,
  input  wire pp4_pkg::cmd_t              q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_carrier_on,
  output logic [pp4_pkg::DUR_W-1:0]       out_duration,
  output logic [pp4_pkg::SYM_W-1:0]       out_symbol,
  output logic                            out_frame_done
);

  localparam logic [2:0] LAST_PULSE = 3'd7;

  logic                         out_valid_r;
  logic                         carrier_r;
  logic [pp4_pkg::DUR_W-1:0]    duration_r;
  logic [pp4_pkg::SYM_W-1:0]    symbol_r;
  logic                         done_r;
  logic [2:0]                   idx_r;

  logic                         slot_free;
  logic                         emit;
  logic [pp4_pkg::SYM_W-1:0]    sym;
  logic                         pulse_carrier;
  logic [pp4_pkg::DUR_W-1:0]    pulse_dur;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = !q_empty && slot_free;
  assign q_pop     = emit && (q_head.is_close || (idx_r == LAST_PULSE));

  // Each symbol is a burst then a gap; pulse index bits [2:1] pick the pair.
  always_comb begin
    if (q_head.is_close) begin
      sym           = '0;
      pulse_carrier = 1'b1;
      pulse_dur     = cfg.burst;
    end else begin
      sym           = q_head.data[{idx_r[2:1], 1'b0} +: pp4_pkg::SYM_W];
      pulse_carrier = !idx_r[0];
      pulse_dur     = idx_r[0] ? cfg.gap[sym] : cfg.burst;
    end
  end

  // Pulse index within the command at the queue head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        idx_r <= q_pop ? 3'd0 : idx_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register holds the descriptor until its transaction completes.
  always_ff @(posedge clk) begin
    if (emit) begin
      carrier_r  <= pulse_carrier;
      duration_r <= pulse_dur;
      symbol_r   <= sym;
      done_r     <= q_head.is_close;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_carrier_on = carrier_r;
  assign out_duration   = duration_r;
  assign out_symbol     = symbol_r;
  assign out_frame_done = done_r;

endmodule

`default_nettype wire

[rtl/core/pp4_ir_frame_transmitter.sv]
`default_nettype none

// PP4 infrared frame transmitter. Frame bytes enter on the in_ channel, the
// last one flagged by in_frame_end; each byte leaves on the out_ channel as
// eight pulse descriptors (burst, gap per 2-bit symbol, low pair first), and a
// final byte adds the CRC-16 low and high bytes when append_crc is set, then a
// closing burst, for 9 or 25 descriptors in all. The back sequencer issues one
// descriptor per cycle while out_ready is high and the queue holds a command; a
// small command queue lets new bytes be taken while earlier ones are still
// being sent. Durations are in clock cycles and are
// set through the APB registers at byte addresses 0 to 20, which should only
// be written while the transmitter is idle.
module pp4_ir_frame_transmitter #(
  parameter int unsigned QUEUE_DEPTH = pp4_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pp4_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                            in_frame_end,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_carrier_on,
  output logic [pp4_pkg::DUR_W-1:0]            out_duration,
  output logic [pp4_pkg::SYM_W-1:0]            out_symbol,
  output logic                                 out_frame_done,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pp4_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [pp4_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pp4_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  pp4_pkg::cfg_t     cfg_r;
  logic              append_r;
  pp4_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  logic              q_push, q_pop, q_full, q_empty;
  pp4_pkg::cmd_t     q_wdata, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst  <= pp4_pkg::BURST_RST;
      cfg_r.gap[0] <= pp4_pkg::GAP0_RST;
      cfg_r.gap[1] <= pp4_pkg::GAP1_RST;
      cfg_r.gap[2] <= pp4_pkg::GAP2_RST;
      cfg_r.gap[3] <= pp4_pkg::GAP3_RST;
      append_r     <= pp4_pkg::APPEND_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pp4_pkg::REG_BURST:  cfg_r.burst  <= pwdata[pp4_pkg::DUR_W-1:0];
        pp4_pkg::REG_GAP0:   cfg_r.gap[0] <= pwdata[pp4_pkg::DUR_W-1:0];
        pp4_pkg::REG_GAP1:   cfg_r.gap[1] <= pwdata[pp4_pkg::DUR_W-1:0];
        pp4_pkg::REG_GAP2:   cfg_r.gap[2] <= pwdata[pp4_pkg::DUR_W-1:0];
        pp4_pkg::REG_GAP3:   cfg_r.gap[3] <= pwdata[pp4_pkg::DUR_W-1:0];
        pp4_pkg::REG_APPEND: append_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back, zero extended.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pp4_pkg::REG_BURST:  prdata[pp4_pkg::DUR_W-1:0] = cfg_r.burst;
      pp4_pkg::REG_GAP0:   prdata[pp4_pkg::DUR_W-1:0] = cfg_r.gap[0];
      pp4_pkg::REG_GAP1:   prdata[pp4_pkg::DUR_W-1:0] = cfg_r.gap[1];
      pp4_pkg::REG_GAP2:   prdata[pp4_pkg::DUR_W-1:0] = cfg_r.gap[2];
      pp4_pkg::REG_GAP3:   prdata[pp4_pkg::DUR_W-1:0] = cfg_r.gap[3];
      pp4_pkg::REG_APPEND: prdata[0] = append_r;
      default:             prdata = '0;
    endcase
  end

  pp4_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .append_crc   (append_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  pp4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  pp4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_carrier_on (out_carrier_on),
    .out_duration   (out_duration),
    .out_symbol     (out_symbol),
    .out_frame_done (out_frame_done)
  );

  // The front never writes into a full queue, and the back never pops an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

  // After the final byte of a frame the input is held off for the tail commands.
  a_tail_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_end) |=> !in_ready)
    else $error("input taken during frame tail");

  // The closing burst is a carrier burst carrying symbol zero.
  a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_carrier_on && (out_symbol == '0)))
    else $error("malformed closing burst");

endmodule

`default_nettype wire

[tb/pp4_ir_frame_transmitter_tb.sv]
`default_nettype none

module pp4_ir_frame_transmitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN = 300;
  localparam int TAIL_CYCLES = 20;
  localparam logic [pp4_pkg::DUR_W-1:0] DUR_MAX = {pp4_pkg::DUR_W{1'b1}};

  typedef struct {
    logic [pp4_pkg::BYTE_W-1:0] data;
    logic                       frame_end;
  } byte_item_t;

  typedef struct {
    logic                      carrier_on;
    logic [pp4_pkg::DUR_W-1:0] duration;
    logic [pp4_pkg::SYM_W-1:0] symbol;
    logic                      frame_done;
  } pulse_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // Block inputs, all driven to known values from time zero.
  logic                           in_valid = 1'b0;
  logic [pp4_pkg::BYTE_W-1:0]     in_data_byte = '0;
  logic                           in_frame_end = 1'b0;
  logic                           out_ready = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [pp4_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pp4_pkg::APB_DATA_W-1:0] pwdata = '0;

  // Block outputs.
  logic                           in_ready;
  logic                           out_valid;
  logic                           out_carrier_on;
  logic [pp4_pkg::DUR_W-1:0]      out_duration;
  logic [pp4_pkg::SYM_W-1:0]      out_symbol;
  logic                           out_frame_done;
  logic [pp4_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  pp4_ir_frame_transmitter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_carrier_on (out_carrier_on),
    .out_duration   (out_duration),
    .out_symbol     (out_symbol),
    .out_frame_done (out_frame_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Bytes waiting to be offered and pulses waiting to come out.
  byte_item_t byte_q[$];
  pulse_t     pulse_q[$];
  byte_item_t cur_byte;

  // Shadow copy of the timing registers and the running CRC.
  logic [pp4_pkg::DUR_W-1:0] burst_len = pp4_pkg::BURST_RST;
  logic [pp4_pkg::DUR_W-1:0] gap_len[pp4_pkg::NUM_SYMS] =
    '{pp4_pkg::GAP0_RST, pp4_pkg::GAP1_RST, pp4_pkg::GAP2_RST, pp4_pkg::GAP3_RST};
  logic                      crc_enable = pp4_pkg::APPEND_RST;
  logic [15:0]               crc_state = pp4_pkg::CRC_INIT;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  // Long receiver hold-off, started once by the stimulus.
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Four symbols of one byte, low pair first, each a burst then a gap.
  task automatic push_byte_pulses(input logic [pp4_pkg::BYTE_W-1:0] b);
    logic [pp4_pkg::SYM_W-1:0] sym;
    for (int s = 0; s < 4; s++) begin
      sym = b[2*s +: 2];
      pulse_q.push_back('{carrier_on: 1'b1, duration: burst_len, symbol: sym,
                          frame_done: 1'b0});
      pulse_q.push_back('{carrier_on: 1'b0, duration: gap_len[sym], symbol: sym,
                          frame_done: 1'b0});
    end
  endtask

  // Expected pulses for one accepted byte, including the frame tail.
  task automatic predict_pulses(input logic [pp4_pkg::BYTE_W-1:0] b,
                                input logic frame_end);
    logic [15:0] c;
    push_byte_pulses(b);
    c = crc_state ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ pp4_pkg::CRC_POLY) : (c >> 1);
    end
    crc_state = c;
    if (frame_end) begin
      if (crc_enable) begin
        push_byte_pulses(crc_state[7:0]);
        push_byte_pulses(crc_state[15:8]);
      end
      pulse_q.push_back('{carrier_on: 1'b1, duration: burst_len, symbol: '0,
                          frame_done: 1'b1});
      crc_state = pp4_pkg::CRC_INIT;
    end
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [pp4_pkg::APB_ADDR_W-1:0] addr,
                                input logic [pp4_pkg::APB_DATA_W-1:0] data);
    pp4_pkg::reg_idx_t idx;
    idx = pp4_pkg::reg_idx_t'(addr >> 2);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pp4_pkg::REG_BURST:  burst_len = data[pp4_pkg::DUR_W-1:0];
      pp4_pkg::REG_GAP0:   gap_len[0] = data[pp4_pkg::DUR_W-1:0];
      pp4_pkg::REG_GAP1:   gap_len[1] = data[pp4_pkg::DUR_W-1:0];
      pp4_pkg::REG_GAP2:   gap_len[2] = data[pp4_pkg::DUR_W-1:0];
      pp4_pkg::REG_GAP3:   gap_len[3] = data[pp4_pkg::DUR_W-1:0];
      pp4_pkg::REG_APPEND: crc_enable = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [pp4_pkg::APB_ADDR_W-1:0] reg_addr(
    input pp4_pkg::reg_idx_t idx);
    return pp4_pkg::APB_ADDR_W'(idx) << 2;
  endfunction

  task automatic write_timing(input logic [pp4_pkg::DUR_W-1:0] burst,
                              input logic [pp4_pkg::DUR_W-1:0] g0,
                              input logic [pp4_pkg::DUR_W-1:0] g1,
                              input logic [pp4_pkg::DUR_W-1:0] g2,
                              input logic [pp4_pkg::DUR_W-1:0] g3,
                              input logic append);
    write_register(reg_addr(pp4_pkg::REG_BURST), pp4_pkg::APB_DATA_W'(burst));
    write_register(reg_addr(pp4_pkg::REG_GAP0), pp4_pkg::APB_DATA_W'(g0));
    write_register(reg_addr(pp4_pkg::REG_GAP1), pp4_pkg::APB_DATA_W'(g1));
    write_register(reg_addr(pp4_pkg::REG_GAP2), pp4_pkg::APB_DATA_W'(g2));
    write_register(reg_addr(pp4_pkg::REG_GAP3), pp4_pkg::APB_DATA_W'(g3));
    write_register(reg_addr(pp4_pkg::REG_APPEND), pp4_pkg::APB_DATA_W'(append));
  endtask

  task automatic random_timing();
    write_timing(pp4_pkg::DUR_W'($urandom_range(DUR_MAX)),
                 pp4_pkg::DUR_W'($urandom_range(DUR_MAX)),
                 pp4_pkg::DUR_W'($urandom_range(DUR_MAX)),
                 pp4_pkg::DUR_W'($urandom_range(DUR_MAX)),
                 pp4_pkg::DUR_W'($urandom_range(DUR_MAX)),
                 1'($urandom_range(1)));
  endtask

  task automatic queue_byte(input logic [pp4_pkg::BYTE_W-1:0] b, input logic frame_end);
    byte_q.push_back('{data: b, frame_end: frame_end});
  endtask

  // Random frames, mostly short, now and then a longer one.
  task automatic queue_frames(input int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(6, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        queue_byte(pp4_pkg::BYTE_W'($urandom_range(255)), i == len - 1);
      end
      left -= len;
    end
  endtask

  // Wait until every byte is taken and every pulse has come out.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || pulse_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: offers bytes from the queue and predicts on each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pulses(cur_byte.data, cur_byte.frame_end);
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_byte = byte_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur_byte.data;
          in_frame_end <= cur_byte.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expected pulse.
  always @(posedge clk) begin
    pulse_t exp_pulse;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pulse carrier=%0b dur=%0d sym=%0d done=%0b",
                                    out_carrier_on, out_duration, out_symbol,
                                    out_frame_done));
        end else begin
          exp_pulse = pulse_q.pop_front();
          if (out_carrier_on !== exp_pulse.carrier_on || out_duration !== exp_pulse.duration ||
              out_symbol !== exp_pulse.symbol || out_frame_done !== exp_pulse.frame_done) begin
            report_mismatch($sformatf(
              "got carrier=%0b dur=%0d sym=%0d done=%0b, want %0b %0d %0d %0b",
              out_carrier_on, out_duration, out_symbol, out_frame_done,
              exp_pulse.carrier_on, exp_pulse.duration, exp_pulse.symbol,
              exp_pulse.frame_done));
          end
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= HOLD_LEN;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: all-zero and all-one bytes, every symbol value, a short frame.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hE4, 1'b0);
    queue_byte(8'h1B, 1'b0);
    queue_byte(8'h55, 1'b1);
    drain();

    // Frames without the CRC tail.
    write_register(reg_addr(pp4_pkg::REG_APPEND), '0);
    queue_byte(8'hAA, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b1);
    drain();

    // Zero durations are passed through unchanged.
    write_timing('0, '0, '0, '0, '0, 1'b1);
    queue_byte(8'hC3, 1'b1);
    drain();

    // Largest durations; bits above the register width are dropped.
    write_timing(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 1'b1);
    write_register(reg_addr(pp4_pkg::REG_BURST), 32'hFFFC_0005);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'h7E, 1'b1);
    drain();

    // Writes to addresses past the last register must leave the timing alone.
    write_register(pp4_pkg::APB_ADDR_W'(24), 32'h0001_2345);
    write_register(pp4_pkg::APB_ADDR_W'(28), 32'hFFFF_FFFF);
    queue_byte(8'h99, 1'b1);
    drain();

    // Shortest nonzero durations.
    write_timing(18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 1'b0);
    queue_byte(8'hE4, 1'b1);
    queue_byte(8'h5A, 1'b1);
    drain();

    // No idling, with a long receiver hold-off so the input backs up.
    random_timing();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    queue_frames(25);
    drain();
    random_timing();
    queue_frames(25);
    drain();

    // Sender idle most of the time; it pauses midway until all pulses are out.
    random_timing();
    send_idle_pct = 62;
    recv_stall_pct = 0;
    queue_frames(25);
    drain();
    queue_frames(25);
    drain();

    // Receiver stalling most of the time.
    random_timing();
    send_idle_pct = 0;
    recv_stall_pct = 62;
    queue_frames(25);
    drain();
    random_timing();
    queue_frames(25);
    drain();

    // Both sides idling now and then.
    random_timing();
    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_frames(25);
    drain();
    write_timing(DUR_MAX, '0, DUR_MAX, '0, DUR_MAX, 1'b1);
    queue_frames(25);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pulse_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected pulses never arrived", pulse_q.size()));
    end
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/pp4_pkg.sv
rtl/core/pp4_front.sv
rtl/core/pp4_queue.sv
rtl/core/pp4_back.sv
rtl/core/pp4_ir_frame_transmitter.sv
tb/pp4_ir_frame_transmitter_tb.sv
